/* rtl/core/control_frame_text_parser_crc8_unit_defines.svh */
// Assertion macros for the control frame parser.
// Used by the top level only; compiled out when SYNTHESIS is defined.
`ifndef CONTROL_FRAME_TEXT_PARSER_CRC8_UNIT_DEFINES_SVH
`define CONTROL_FRAME_TEXT_PARSER_CRC8_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define CTFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked through reset as well
`define CTFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTFP_ASSERT(lbl, prop, msg)
`define CTFP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/core/ctfp_pkg.sv */
// Shared types, constants and the CRC-8 step for the control frame parser.
// No dependencies.
package ctfp_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] seq_value;
    logic [7:0] flag_bits;
    logic [7:0] throttle_value;
    logic [7:0] roll_value;
    logic [7:0] pitch_value;
    logic [7:0] yaw_value;
    logic [7:0] received_check;
    logic [7:0] computed_check;
  } out_item_t;

  // classified character, front to back
  typedef struct packed {
    logic       last;
    logic       is_pipe;
    logic       is_digit;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic       is_type;
    logic [3:0] digit;
  } cls_t;

  localparam logic [7:0] PIPE_CHAR  = 8'h7C;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] TYPE_RESET = 8'd67;
  localparam int         STORED_FIELDS = 6;

  localparam logic [3:0] PH_PREFIX = 4'd0;
  localparam logic [3:0] PH_FIRST  = 4'd1;
  localparam logic [3:0] PH_LAST_STORED = 4'd6;
  localparam logic [3:0] PH_CHECK  = 4'd7;
  localparam logic [3:0] PH_TAIL   = 4'd8;
  localparam logic [3:0] PH_FAIL   = 4'd9;

  localparam logic [1:0] PT_NONE  = 2'd0;
  localparam logic [1:0] PT_MATCH = 2'd1;
  localparam logic [1:0] PT_BAD   = 2'd2;

  localparam logic [1:0] NP_BLANK = 2'd0;
  localparam logic [1:0] NP_NUM   = 2'd1;
  localparam logic [1:0] NP_STOP  = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_PREFIX = 2'd1;
  localparam logic [1:0] ERR_EMPTY  = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_PREFIX = 3'd1;
  localparam logic [2:0] ST_FEW    = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_CRC    = 3'd4;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/ctfp_front.sv */
// Front end: type register, character classification and a two-entry item queue.
// Depends on ctfp_pkg.
module ctfp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctfp_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output ctfp_pkg::cls_t     q_item
);

  logic [7:0]     type_r;
  logic [1:0]     count_r, count_nxt;
  logic           wr_ptr_r, rd_ptr_r;
  ctfp_pkg::cls_t q_r [2];
  ctfp_pkg::cls_t cls;
  logic           push, pop;

  always_comb begin
    logic [7:0] c;
    c            = in_data.char_byte;
    cls.last     = in_data.last_char;
    cls.is_pipe  = (c == ctfp_pkg::PIPE_CHAR);
    cls.is_digit = c inside {[8'h30:8'h39]};
    cls.is_blank = c inside {8'h20, [8'h09:8'h0D]};
    cls.is_sign  = c inside {8'h2B, 8'h2D};
    cls.is_minus = (c == 8'h2D);
    cls.is_type  = (c == type_r);
    cls.digit    = c[3:0];
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r   <= ctfp_pkg::TYPE_RESET;
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        type_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* rtl/core/ctfp_back.sv */
// Back end: frame parser, field store, CRC-8 and the result register.
// Depends on ctfp_pkg.
module ctfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  ctfp_pkg::cls_t      q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ctfp_pkg::out_item_t out_data
);

  logic [3:0] phase_r, phase_nxt;
  logic [1:0] ptrack_r, ptrack_nxt;
  logic [1:0] nphase_r, nphase_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       neg_r, neg_nxt;
  logic       nonempty_r, nonempty_nxt;
  logic [1:0] err_r, err_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] store_r [ctfp_pkg::STORED_FIELDS];
  logic       store_we;
  logic [2:0] store_idx;
  logic [7:0] store_val;
  logic                out_valid_r, out_valid_nxt;
  ctfp_pkg::out_item_t out_data_r, out_data_nxt;
  logic       step;

  assign q_ready   = !out_valid_r || out_ready;
  assign step      = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [3:0] ph;
    logic [1:0] pt, np, er;
    logic [7:0] acc, crc, v;
    logic       ng, ne;
    logic [2:0] st;
    logic [7:0] view [ctfp_pkg::STORED_FIELDS];

    ph = phase_r;  pt = ptrack_r;  np = nphase_r;  er = err_r;
    acc = acc_r;   crc = crc_r;    ng = neg_r;     ne = nonempty_r;
    v = 8'd0;  st = ctfp_pkg::ST_OK;
    store_we = 1'b0;  store_idx = 3'd0;  store_val = 8'd0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    for (int i = 0; i < ctfp_pkg::STORED_FIELDS; i++) begin
      view[i] = store_r[i];
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (step) begin
      if (ph == ctfp_pkg::PH_PREFIX) begin
        if (q_item.is_pipe) begin
          if (pt == ctfp_pkg::PT_MATCH) begin
            ph = ctfp_pkg::PH_FIRST;
            np = ctfp_pkg::NP_BLANK;  acc = 8'd0;  ng = 1'b0;  ne = 1'b0;
          end else begin
            er = ctfp_pkg::ERR_PREFIX;
            ph = ctfp_pkg::PH_FAIL;
          end
        end else if (pt == ctfp_pkg::PT_NONE && q_item.is_type) begin
          pt = ctfp_pkg::PT_MATCH;
        end else begin
          pt = ctfp_pkg::PT_BAD;
        end
      end else if (ph >= ctfp_pkg::PH_FIRST && ph <= ctfp_pkg::PH_CHECK) begin
        if (q_item.is_pipe) begin
          v = ng ? (~acc + 8'd1) : acc;
          if (!ne && er == ctfp_pkg::ERR_NONE) begin
            er = ctfp_pkg::ERR_EMPTY;
          end
          if (ph <= ctfp_pkg::PH_LAST_STORED) begin
            store_we  = 1'b1;
            store_idx = 3'(ph - 4'd1);
            store_val = v;
            view[store_idx] = v;
            crc = ctfp_pkg::crc_fold(crc, v);
            ph  = ph + 4'd1;
            np = ctfp_pkg::NP_BLANK;  acc = 8'd0;  ng = 1'b0;  ne = 1'b0;
          end else begin
            acc = v;  ng = 1'b0;  np = ctfp_pkg::NP_STOP;
            ph  = ctfp_pkg::PH_TAIL;
          end
        end else begin
          ne = 1'b1;
          if (np != ctfp_pkg::NP_STOP) begin
            if (q_item.is_digit) begin
              acc = (acc << 3) + (acc << 1) + {4'd0, q_item.digit};
              np  = ctfp_pkg::NP_NUM;
            end else if (np == ctfp_pkg::NP_BLANK) begin
              if (q_item.is_sign) begin
                ng = q_item.is_minus;
                np = ctfp_pkg::NP_NUM;
              end else if (!q_item.is_blank) begin
                np = ctfp_pkg::NP_STOP;
              end
            end else begin
              np = ctfp_pkg::NP_STOP;
            end
          end
        end
      end

      if (q_item.last) begin
        // end of frame closes the check field
        if (ph == ctfp_pkg::PH_CHECK) begin
          acc = ng ? (~acc + 8'd1) : acc;
          if (!ne && er == ctfp_pkg::ERR_NONE) begin
            er = ctfp_pkg::ERR_EMPTY;
          end
          ph = ctfp_pkg::PH_TAIL;
        end
        if (er == ctfp_pkg::ERR_PREFIX || ph == ctfp_pkg::PH_PREFIX ||
            ph == ctfp_pkg::PH_FAIL) begin
          st = ctfp_pkg::ST_PREFIX;
        end else if (ph < ctfp_pkg::PH_CHECK) begin
          st = ctfp_pkg::ST_FEW;
        end else if (er == ctfp_pkg::ERR_EMPTY) begin
          st = ctfp_pkg::ST_EMPTY;
        end else if (acc != crc) begin
          st = ctfp_pkg::ST_CRC;
        end else begin
          st = ctfp_pkg::ST_OK;
        end

        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_data_nxt.status = st;
        if (st == ctfp_pkg::ST_OK || st == ctfp_pkg::ST_CRC) begin
          out_data_nxt.seq_value      = view[0];
          out_data_nxt.flag_bits      = view[1];
          out_data_nxt.throttle_value = view[2];
          out_data_nxt.roll_value     = view[3];
          out_data_nxt.pitch_value    = view[4];
          out_data_nxt.yaw_value      = view[5];
          out_data_nxt.received_check = acc;
          out_data_nxt.computed_check = crc;
        end

        ph = ctfp_pkg::PH_PREFIX;  pt = ctfp_pkg::PT_NONE;
        np = ctfp_pkg::NP_BLANK;   acc = 8'd0;  ng = 1'b0;  ne = 1'b0;
        er = ctfp_pkg::ERR_NONE;   crc = 8'd0;
      end
    end

    phase_nxt = ph;  ptrack_nxt = pt;  nphase_nxt = np;  err_nxt = er;
    acc_nxt = acc;   crc_nxt = crc;    neg_nxt = ng;     nonempty_nxt = ne;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ctfp_pkg::PH_PREFIX;
      ptrack_r    <= ctfp_pkg::PT_NONE;
      nphase_r    <= ctfp_pkg::NP_BLANK;
      acc_r       <= 8'd0;
      neg_r       <= 1'b0;
      nonempty_r  <= 1'b0;
      err_r       <= ctfp_pkg::ERR_NONE;
      crc_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ptrack_r    <= ptrack_nxt;
      nphase_r    <= nphase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      nonempty_r  <= nonempty_nxt;
      err_r       <= err_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (store_we) begin
      store_r[store_idx] <= store_val;
    end
  end

endmodule

/* rtl/core/control_frame_text_parser_crc8_unit.sv */
// Control frame text parser with CRC-8 check: top level.
// Depends on ctfp_pkg, ctfp_front, ctfp_back and the unit's defines header.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one ASCII character per
//   item; in_data.last_char marks the final character of a frame.
//   Output channel (out_valid/out_ready/out_data) gives one result item per
//   frame: status, six field bytes, received and computed CRC-8.
//   cfg_we/cfg_wdata write the expected type letter (reset 'C'); write only
//   while no frame is in flight.
// Path: an accepted character is written into the front queue; the parser
//   step takes it from the queue head and loads the result register.
// Throughput: one character per cycle while no result is held by a stall;
//   the parser step in the back end handles each character as it is popped.
// Reset: synchronous, active low; empties the queue, clears the parser state
//   and the result valid flag; the type letter returns to 'C'.
// Stall: a held result stops the parser; the two-entry queue then fills and
//   in_ready drops. No item is lost or repeated.
`include "control_frame_text_parser_crc8_unit_defines.svh"

module control_frame_text_parser_crc8_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ctfp_pkg::out_item_t out_data
);

  logic           q_valid;
  logic           q_ready;
  ctfp_pkg::cls_t q_item;

  ctfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  ctfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `CTFP_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `CTFP_ASSERT(a_stall_blocks_parser, out_valid && !out_ready |-> !q_ready, "parser ran during output stall")

  `CTFP_ASSERT(a_error_fields_zero, out_valid && (out_data.status == ctfp_pkg::ST_PREFIX || out_data.status == ctfp_pkg::ST_FEW || out_data.status == ctfp_pkg::ST_EMPTY) |-> out_data.seq_value == 8'd0 && out_data.computed_check == 8'd0, "error result carries field data")

endmodule
